[design/olist_pkg.sv]
// Shared types and constants for the ordered list engine.
// No dependencies; imported by olist_cell and ordered_list_engine.
package olist_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned IN_TDATA_W   = 40;
  localparam int unsigned OUT_TDATA_W  = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_READ   = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_UPDATE = 3'd3,
    MODE_FIND   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  // Broadcast to every cell of the row in the cycle a beat is taken.
  typedef struct packed {
    logic             append;
    logic             update;
    logic             shift;
    logic             find;
    logic             read;
    logic             capture;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

[design/olist_cell.sv]
// One storage cell of the ordered list row: holds one entry, compares it
// and takes its neighbour's entry when the list closes a gap. Uses olist_pkg.
module olist_cell
  import olist_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned LW  = 5
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [LW-1:0]    tgt_i,
  input  logic [LW-1:0]    used_i,
  input  logic [VAL_W-1:0] next_i,
  output logic [VAL_W-1:0] entry_o,
  output logic             match_o,
  output logic [VAL_W-1:0] rd_o
);

  localparam logic [LW-1:0] MyIdx = LW'(IDX);

  logic [VAL_W-1:0] entry_q;
  logic             match_q;
  logic [VAL_W-1:0] rd_q;
  logic             in_use;
  logic             at_tgt;

  assign in_use = MyIdx < used_i;
  assign at_tgt = MyIdx == tgt_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (MyIdx == used_i)) begin
      entry_q <= cmd_i.value;
    end else if (cmd_i.update && at_tgt) begin
      entry_q <= cmd_i.value;
    end else if (cmd_i.shift && (MyIdx >= tgt_i)) begin
      entry_q <= next_i;
    end
    if (cmd_i.capture) begin
      match_q <= cmd_i.find && in_use && (entry_q == cmd_i.value);
      rd_q    <= (cmd_i.read && at_tgt) ? entry_q : '0;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign rd_o    = rd_q;

endmodule

[design/ordered_list_engine.sv]
// Ordered list engine top level: request/result streams, count register,
// control and result resolution. Uses olist_pkg and olist_cell.
//
// Usage:
//   Requests arrive as beats on the s_axis group; tdata carries mode,
//   position and value. Each request yields exactly one result beat on the
//   m_axis group carrying ok, read_value, found_at and entry_count.
//   In the cycle a request is taken, every cell of the row acts on it at
//   once (append, update, shift for remove, compare for find, select for
//   read); in the resolve step that follows, the match flags are reduced
//   to the first matching position and the result is written into the
//   output register once it is free. No new request is taken until the
//   resolve step between row update and output register has finished.
//   The next request may be taken while a finished result still waits in
//   the output register.
//   If the receiver stalls, the result is held and the engine waits in its
//   resolve step, not taking new requests, until the register frees up.
//   Reset empties the list (count 0) and drops any pending result; stored
//   values are left undefined until written.
module ordered_list_engine
  import olist_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] mode, [7:3] position, [39:8] value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] ok, [32:1] read_value, [37:33] found_at, [42:38] entry_count,
  // [47:43] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {
    ST_IDLE,
    ST_RESOLVE
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [CW-1:0]          used_q;
  logic [CW-1:0]          used_d;
  logic                   ok_q;
  logic                   ok_d;
  logic                   find_q;

  logic [MODE_W-1:0]      in_mode;
  logic [POS_W-1:0]       in_pos;
  logic [VAL_W-1:0]       in_value;
  logic                   accept;
  logic [LW-1:0]          used_lw;
  logic [LW-1:0]          tgt;
  logic                   pos_valid;
  cell_cmd_t              cmd;

  logic [VAL_W-1:0]       ent_w   [CAPACITY];
  logic [VAL_W-1:0]       rd_w    [CAPACITY];
  logic [CAPACITY-1:0]    match_w;
  logic [CAPACITY-1:0]    first_w;
  logic [CW-1:0]          found_w;
  logic [VAL_W-1:0]       rd_val_w;
  logic                   out_free;
  logic [OUT_TDATA_W-1:0] result_w;

  assign in_mode  = s_axis_tdata[2:0];
  assign in_pos   = s_axis_tdata[7:3];
  assign in_value = s_axis_tdata[39:8];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign used_lw   = LW'(used_q);
  assign tgt       = LW'(in_pos) - LW'(1);
  assign pos_valid = (in_pos != '0) && (LW'(in_pos) <= used_lw);

  always_comb begin
    cmd         = '0;
    cmd.value   = in_value;
    cmd.capture = accept;
    ok_d        = 1'b0;
    used_d      = used_q;
    case (in_mode)
      MODE_APPEND: begin
        ok_d = used_q < CW'(CAPACITY);
        cmd.append = accept && ok_d;
        if (ok_d) used_d = used_q + CW'(1);
      end
      MODE_READ: begin
        ok_d = pos_valid;
        cmd.read = accept && ok_d;
      end
      MODE_REMOVE: begin
        ok_d = pos_valid;
        cmd.shift = accept && ok_d;
        if (ok_d) used_d = used_q - CW'(1);
      end
      MODE_UPDATE: begin
        ok_d = pos_valid;
        cmd.update = accept && ok_d;
      end
      MODE_FIND: begin
        ok_d = 1'b1;
        cmd.find = accept;
      end
      MODE_CLEAR: begin
        ok_d   = 1'b1;
        used_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic [VAL_W-1:0] next_w;
    if (i == CAPACITY - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_link
      assign next_w = ent_w[i+1];
    end
    olist_cell #(
      .IDX (i),
      .LW  (LW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .tgt_i   (tgt),
      .used_i  (used_lw),
      .next_i  (next_w),
      .entry_o (ent_w[i]),
      .match_o (match_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  // Isolate the lowest set match flag, then encode its position.
  assign first_w = match_w & (~match_w + CAPACITY'(1));

  always_comb begin
    found_w  = '0;
    rd_val_w = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_w[i]) found_w = found_w | CW'(i + 1);
      rd_val_w = rd_val_w | rd_w[i];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign result_w = {5'd0, POS_W'(used_q), find_q ? POS_W'(found_w) : POS_W'(0),
                     rd_val_w, ok_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      used_q      <= '0;
    end else begin
      if ((state_q == ST_RESOLVE) && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= result_w;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            used_q  <= used_d;
            state_q <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q   <= ok_d;
      find_q <= (in_mode == MODE_FIND);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RESOLVE) && !s_axis_tready)
    else $error("request not followed by resolve step");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RESOLVE)
    else $error("result beat raised outside resolve step");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[37:33] != '0)) |-> m_axis_tdata[0])
    else $error("found position reported without success");

endmodule
